[hw/rtl/pfa_pkg.sv]
// shared types and constants of the page frame allocator
package pfa_pkg;

    localparam int ADDR_BITS   = 52;
    localparam int BATCH_W     = 13;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;

    localparam logic [BATCH_W-1:0]   FILL_BATCH_RESET  = 13'd512;
    localparam logic [ADDR_BITS-1:0] MIN_ADDRESS_RESET = 52'h0_0000_0010_0000;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_BATCH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ADDRESS = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_REGION = 2'd0,
        ACT_ALLOC      = 2'd1,
        ACT_FREE       = 2'd2,
        ACT_PRIME      = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_OUT_OF_MEM  = 2'd1,
        ST_STACK_FULL  = 2'd2,
        ST_TABLE_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK_READ,
        S_WALK_EVAL,
        S_WALK_PUSH,
        S_POP,
        S_POP_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    walk_init;
        logic    add_region;
        logic    free_push;
        logic    region_read;
        logic    region_eval;
        logic    push;
        logic    region_close;
        logic    pop_read;
        logic    pop_capture;
        logic    set_status;
        status_t status;
        logic    load_out;
    } pfa_cmd_t;

    typedef struct packed {
        action_t act;
        logic    table_full;
        logic    stack_full;
        logic    stack_empty;
        logic    walk_more;
        logic    region_skip;
        logic    push_more;
    } pfa_stat_t;

endpackage

[hw/rtl/page_frame_allocator_unit.sv]
// page frame allocator top level: controller, datapath and ports
// add region and free: dispatch, then done; prime takes that path on a full stack, else walks
// allocate from a non-empty stack: dispatch, pop, pop wait and done (registered stack read)
// a refill walk reads and evaluates each region, then skips it or pushes its frames and closes it
// a result waiting on result_stall holds the next transaction in the done state
// rst_n is asynchronous: counts and fill position clear, fill_batch 512, min_address 0x100000
module page_frame_allocator_unit #(
    parameter int STACK_DEPTH = 4096,
    parameter int MAX_REGIONS = 32,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pfa_pkg::ADDR_BITS-1:0]        cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [pfa_pkg::ACTION_W-1:0]         action,
    input  logic [pfa_pkg::ADDR_BITS-1:0]        region_base,
    input  logic [pfa_pkg::ADDR_BITS-1:0]        region_length,
    input  logic                                 region_usable,
    input  logic [pfa_pkg::ADDR_BITS-1:0]        freed_page,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [pfa_pkg::STATUS_W-1:0]         status,
    output logic [pfa_pkg::ADDR_BITS-1:0]        alloc_addr,
    output logic [pfa_pkg::BATCH_W-1:0]          refill_count
);

    pfa_pkg::pfa_cmd_t  cmd;
    pfa_pkg::pfa_stat_t stat;

    pfa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    pfa_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .region_base   (region_base),
        .region_length (region_length),
        .region_usable (region_usable),
        .freed_page    (freed_page),
        .status        (status),
        .alloc_addr    (alloc_addr),
        .refill_count  (refill_count),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[hw/rtl/pfa_ram.sv]
// generic single-write, single-read ram with registered read data
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/pfa_ctrl.sv]
// allocator controller: sequences add, free, refill walk and pop
module pfa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  pfa_pkg::pfa_stat_t  stat,
    output pfa_pkg::pfa_cmd_t   cmd
);

    pfa_pkg::state_t state_reg;
    pfa_pkg::state_t state_next;
    logic            result_valid_reg;
    logic            result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pfa_pkg::S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = pfa_pkg::ST_OK;
        case (state_reg)
            pfa_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = pfa_pkg::S_DISPATCH;
                end
            end
            pfa_pkg::S_DISPATCH:
            begin
                cmd.walk_init = 1'b1;
                case (stat.act)
                    pfa_pkg::ACT_ADD_REGION:
                    begin
                        if (stat.table_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = pfa_pkg::ST_TABLE_FULL;
                        end
                        else
                        begin
                            cmd.add_region = 1'b1;
                        end
                        state_next = pfa_pkg::S_DONE;
                    end
                    pfa_pkg::ACT_FREE:
                    begin
                        if (stat.stack_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = pfa_pkg::ST_STACK_FULL;
                        end
                        else
                        begin
                            cmd.free_push = 1'b1;
                        end
                        state_next = pfa_pkg::S_DONE;
                    end
                    pfa_pkg::ACT_ALLOC:
                    begin
                        state_next = stat.stack_empty ? pfa_pkg::S_WALK_READ : pfa_pkg::S_POP;
                    end
                    default:
                    begin
                        if (stat.stack_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = pfa_pkg::ST_STACK_FULL;
                            state_next     = pfa_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = pfa_pkg::S_WALK_READ;
                        end
                    end
                endcase
            end
            pfa_pkg::S_WALK_READ:
            begin
                if (stat.walk_more)
                begin
                    cmd.region_read = 1'b1;
                    state_next      = pfa_pkg::S_WALK_EVAL;
                end
                else if (stat.act == pfa_pkg::ACT_ALLOC)
                begin
                    state_next = pfa_pkg::S_POP;
                end
                else
                begin
                    state_next = pfa_pkg::S_DONE;
                end
            end
            pfa_pkg::S_WALK_EVAL:
            begin
                cmd.region_eval = 1'b1;
                state_next = stat.region_skip ? pfa_pkg::S_WALK_READ : pfa_pkg::S_WALK_PUSH;
            end
            pfa_pkg::S_WALK_PUSH:
            begin
                if (stat.push_more)
                begin
                    cmd.push = 1'b1;
                end
                else
                begin
                    cmd.region_close = 1'b1;
                    state_next       = pfa_pkg::S_WALK_READ;
                end
            end
            pfa_pkg::S_POP:
            begin
                if (stat.stack_empty)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pfa_pkg::ST_OUT_OF_MEM;
                    state_next     = pfa_pkg::S_DONE;
                end
                else
                begin
                    cmd.pop_read = 1'b1;
                    state_next   = pfa_pkg::S_POP_WAIT;
                end
            end
            pfa_pkg::S_POP_WAIT:
            begin
                cmd.pop_capture = 1'b1;
                state_next      = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = pfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    assign item_stall   = (state_reg != pfa_pkg::S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

[hw/rtl/pfa_datapath.sv]
// allocator datapath: config, counters, region table, frame stack and result registers
module pfa_datapath #(
    parameter int STACK_DEPTH = 4096,
    parameter int MAX_REGIONS = 32,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [pfa_pkg::ADDR_BITS-1:0]         cfg_data,
    input  logic [pfa_pkg::ACTION_W-1:0]          action,
    input  logic [pfa_pkg::ADDR_BITS-1:0]         region_base,
    input  logic [pfa_pkg::ADDR_BITS-1:0]         region_length,
    input  logic                                  region_usable,
    input  logic [pfa_pkg::ADDR_BITS-1:0]         freed_page,
    output logic [pfa_pkg::STATUS_W-1:0]          status,
    output logic [pfa_pkg::ADDR_BITS-1:0]         alloc_addr,
    output logic [pfa_pkg::BATCH_W-1:0]           refill_count,
    input  pfa_pkg::pfa_cmd_t                     cmd,
    output pfa_pkg::pfa_stat_t                    stat
);

    localparam int AW         = pfa_pkg::ADDR_BITS;
    localparam int BW         = pfa_pkg::BATCH_W;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FRAME_W    = AW - PAGE_SHIFT;
    localparam int EF_W       = FRAME_W + 1;
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int SA_W       = $clog2(STACK_DEPTH);
    localparam int RC_W       = $clog2(MAX_REGIONS + 1);
    localparam int RA_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int ENT_W      = 2 * EF_W + 1;
    localparam int LIM_W      = (CNT_W > BW) ? CNT_W : BW;

    localparam logic [EF_W-1:0]  TOP_FRAME = {1'b1, {FRAME_W{1'b0}}};
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(STACK_DEPTH);
    localparam logic [RC_W-1:0]  MAXR_C    = RC_W'(MAX_REGIONS);

    // configuration and control state
    logic [BW-1:0]      fill_batch_reg;
    logic [AW-1:0]      min_address_reg;
    logic [CNT_W-1:0]   stack_count_reg;
    logic [RC_W-1:0]    region_count_reg;
    logic [RC_W-1:0]    cursor_reg;
    logic [FRAME_W-1:0] offset_reg;

    // item and walk working registers
    pfa_pkg::action_t   act_reg;
    logic [AW-1:0]      base_reg;
    logic [AW-1:0]      len_reg;
    logic               usable_reg;
    logic [AW-1:0]      freed_reg;
    logic [EF_W-1:0]    min_frame_reg;
    logic [BW-1:0]      limit_reg;
    logic [BW-1:0]      added_reg;
    logic [EF_W-1:0]    next_reg;
    logic [EF_W-1:0]    end_reg;
    pfa_pkg::status_t   res_status_reg;
    logic [AW-1:0]      res_page_reg;
    logic [pfa_pkg::STATUS_W-1:0] status_reg;
    logic [AW-1:0]      alloc_addr_reg;
    logic [BW-1:0]      refill_count_reg;

    logic [EF_W-1:0]      start_frame;
    logic [PAGE_SHIFT:0]  low_sum;
    logic [EF_W-1:0]      end_raw;
    logic [EF_W-1:0]      end_frame;
    logic [EF_W-1:0]      min_ceil;
    logic [CNT_W-1:0]     room;
    logic [BW-1:0]        limit_next;
    logic [CNT_W-1:0]     count_dec;
    logic [ENT_W-1:0]     ent_wdata;
    logic [ENT_W-1:0]     ent_rdata;
    logic                 ent_ok;
    logic [EF_W-1:0]      ent_start;
    logic [EF_W-1:0]      ent_end;
    logic [EF_W-1:0]      s_eff;
    logic [EF_W-1:0]      next_start;
    logic                 skip;
    logic                 stack_we;
    logic [FRAME_W-1:0]   stack_wdata;
    logic [FRAME_W-1:0]   stack_rdata;

    // region entry in frame units, end clamped to the top of the address space
    assign start_frame = {1'b0, base_reg[AW-1:PAGE_SHIFT]}
                       + EF_W'(|base_reg[PAGE_SHIFT-1:0]);
    assign low_sum     = {1'b0, base_reg[PAGE_SHIFT-1:0]} + {1'b0, len_reg[PAGE_SHIFT-1:0]};
    assign end_raw     = {1'b0, base_reg[AW-1:PAGE_SHIFT]} + {1'b0, len_reg[AW-1:PAGE_SHIFT]}
                       + EF_W'(low_sum[PAGE_SHIFT]);
    assign end_frame   = (end_raw > TOP_FRAME) ? TOP_FRAME : end_raw;
    assign ent_wdata   = {usable_reg, start_frame, end_frame};

    assign min_ceil    = {1'b0, min_address_reg[AW-1:PAGE_SHIFT]}
                       + EF_W'(|min_address_reg[PAGE_SHIFT-1:0]);
    assign room        = DEPTH_C - stack_count_reg;
    assign limit_next  = (LIM_W'(room) < LIM_W'(fill_batch_reg)) ? BW'(room) : fill_batch_reg;
    assign count_dec   = stack_count_reg - CNT_W'(1);

    assign ent_ok      = ent_rdata[ENT_W-1];
    assign ent_start   = ent_rdata[2*EF_W-1:EF_W];
    assign ent_end     = ent_rdata[EF_W-1:0];
    assign s_eff       = (ent_start < min_frame_reg) ? min_frame_reg : ent_start;
    assign skip        = !ent_ok || (ent_end <= s_eff);
    assign next_start  = ({1'b0, offset_reg} < s_eff) ? s_eff : {1'b0, offset_reg};

    assign stack_we    = cmd.free_push || cmd.push;
    assign stack_wdata = cmd.push ? next_reg[FRAME_W-1:0] : freed_reg[AW-1:PAGE_SHIFT];

    assign stat.act         = act_reg;
    assign stat.table_full  = (region_count_reg >= MAXR_C);
    assign stat.stack_full  = (stack_count_reg >= DEPTH_C);
    assign stat.stack_empty = (stack_count_reg == '0);
    assign stat.walk_more   = (cursor_reg < region_count_reg) && (added_reg < limit_reg);
    assign stat.region_skip = skip;
    assign stat.push_more   = (next_reg < end_reg) && (added_reg < limit_reg);

    pfa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_REGIONS)
    ) u_region_ram (
        .clk   (clk),
        .we    (cmd.add_region),
        .waddr (region_count_reg[RA_W-1:0]),
        .wdata (ent_wdata),
        .re    (cmd.region_read),
        .raddr (cursor_reg[RA_W-1:0]),
        .rdata (ent_rdata)
    );

    pfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_count_reg[SA_W-1:0]),
        .wdata (stack_wdata),
        .re    (cmd.pop_read),
        .raddr (count_dec[SA_W-1:0]),
        .rdata (stack_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_batch_reg   <= pfa_pkg::FILL_BATCH_RESET;
            min_address_reg  <= pfa_pkg::MIN_ADDRESS_RESET;
            stack_count_reg  <= '0;
            region_count_reg <= '0;
            cursor_reg       <= '0;
            offset_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pfa_pkg::CFG_FILL_BATCH:  fill_batch_reg  <= cfg_data[BW-1:0];
                    pfa_pkg::CFG_MIN_ADDRESS: min_address_reg <= cfg_data;
                    default:                  ;
                endcase
            end
            if (cmd.add_region)
            begin
                region_count_reg <= region_count_reg + RC_W'(1);
            end
            if (stack_we)
            begin
                stack_count_reg <= stack_count_reg + CNT_W'(1);
            end
            else if (cmd.pop_read)
            begin
                stack_count_reg <= count_dec;
            end
            if (cmd.region_eval && skip)
            begin
                cursor_reg <= cursor_reg + RC_W'(1);
                offset_reg <= '0;
            end
            else if (cmd.region_close)
            begin
                if (next_reg >= end_reg)
                begin
                    cursor_reg <= cursor_reg + RC_W'(1);
                    offset_reg <= '0;
                end
                else
                begin
                    offset_reg <= next_reg[FRAME_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg        <= pfa_pkg::action_t'(action);
            base_reg       <= region_base;
            len_reg        <= region_length;
            usable_reg     <= region_usable;
            freed_reg      <= freed_page;
            added_reg      <= '0;
            res_status_reg <= pfa_pkg::ST_OK;
            res_page_reg   <= '0;
        end
        if (cmd.walk_init)
        begin
            min_frame_reg <= min_ceil;
            limit_reg     <= limit_next;
        end
        if (cmd.region_eval)
        begin
            next_reg <= next_start;
            end_reg  <= ent_end;
        end
        if (cmd.push)
        begin
            next_reg  <= next_reg + EF_W'(1);
            added_reg <= added_reg + BW'(1);
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.pop_capture)
        begin
            res_page_reg <= {stack_rdata, {PAGE_SHIFT{1'b0}}};
        end
        if (cmd.load_out)
        begin
            status_reg       <= res_status_reg;
            alloc_addr_reg   <= res_page_reg;
            refill_count_reg <= added_reg;
        end
    end

    assign status       = status_reg;
    assign alloc_addr   = alloc_addr_reg;
    assign refill_count = refill_count_reg;

endmodule

[hw/rtl/pfa_checker.sv]
// port-level checks for the page frame allocator, bound to the top level
module pfa_checker #(
    parameter int PAGE_BYTES = 4096
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 item_valid,
    input logic                                 item_stall,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic [pfa_pkg::STATUS_W-1:0]         status,
    input logic [pfa_pkg::ADDR_BITS-1:0]        alloc_addr,
    input logic [pfa_pkg::BATCH_W-1:0]          refill_count
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(status) && $stable(alloc_addr) && $stable(refill_count))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second transaction taken while one is in flight");

    a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> alloc_addr[PAGE_SHIFT-1:0] == '0)
        else $error("page address not page aligned");

    a_fail_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != pfa_pkg::ST_OK |-> alloc_addr == '0)
        else $error("page address given with failing status");

endmodule

bind page_frame_allocator_unit pfa_checker #(.PAGE_BYTES(PAGE_BYTES)) u_pfa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .alloc_addr   (alloc_addr),
    .refill_count (refill_count)
);
